@@ rtl/zhr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zhr_pkg
// Shared constants and the CRC-16 byte update for the ZMODEM header receiver.
// ----------------------------------------------------------------------------
package zhr_pkg;

  localparam int GarbageWidth = 10;
  localparam int CancelWidth  = 4;

  // Register reset values
  localparam logic [GarbageWidth-1:0] GARBAGE_LIMIT_RESET = 10'd1000;
  localparam logic [CancelWidth-1:0]  CANCEL_RUN_RESET    = 4'd5;

  // Configuration register indexes
  localparam logic CFG_GARBAGE_LIMIT = 1'b0;
  localparam logic CFG_CANCEL_RUN    = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_CANCEL = 2'd2;
  localparam logic [1:0] ST_IOFAIL = 2'd3;

  // Special characters, compared on the low seven bits unless noted
  localparam logic [6:0] CH_XON    = 7'h11;
  localparam logic [6:0] CH_XOFF   = 7'h13;
  localparam logic [6:0] CH_CAN    = 7'h18;
  localparam logic [6:0] CH_PAD    = 7'h2A;
  localparam logic [6:0] CH_BIN16  = 7'h41;
  localparam logic [6:0] CH_HEX    = 7'h42;
  localparam logic [6:0] CH_LF     = 7'h0A;
  localparam logic [7:0] ESC_BYTE  = 8'h18;
  localparam logic [7:0] ESC_RUB0  = 8'h6C;
  localparam logic [7:0] ESC_RUB1  = 8'h6D;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One byte through the CCITT CRC-16, most significant bit first.
  function automatic logic [15:0] zhr_crc_step(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

@@ rtl/zmodem_header_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zmodem_header_receiver
// Hunts for a ZMODEM CRC-16 header in a byte stream and decodes it.
// ----------------------------------------------------------------------------
// The block takes one received byte (or one I/O failure) per clock cycle and
// can take a new one in every cycle while the result side keeps up. Each
// transfer is held in an input register and decoded by a single pass of logic
// (including an unrolled CRC-16 byte update). Where it completes, cancels or
// breaks a header, or holds an I/O failure, one result is written into the
// output register. After every result the decoder returns to the hunt for the
// next header; the garbage limit and cancel run registers are kept.
// Configuration is always ready and should only be written while idle.
module zmodem_header_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        io_fail,
  input  wire logic [2:0]  fail_code,
  // Result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [7:0]       frame_type,
  output logic [31:0]      header_value,
  output logic             hex_framed,
  output logic [2:0]       failure_kind,
  // Configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [zhr_pkg::GarbageWidth-1:0] cfg_data
);
  import zhr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEX,
    PH_BIN,
    PH_TRAIL
  } phase_t;

  // Configuration registers
  logic [GarbageWidth-1:0] garbage_limit;
  logic [CancelWidth-1:0]  cancel_run;

  // Input register
  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_fail;
  logic [2:0] item_code;

  // Decoder state
  phase_t                  phase;
  logic [1:0]              prefix_progress;
  logic                    digit_index;
  logic                    escape_seen;
  logic [7:0]              byte_acc;
  logic [2:0]              bytes_taken;
  logic [15:0]             running_crc;
  logic [GarbageWidth-1:0] garbage_count;
  logic [CancelWidth-1:0]  cancel_count;
  logic                    hex_mode;
  logic [7:0]              type_byte;
  logic [31:0]             data_word;

  // Next values
  phase_t                  phase_next;
  logic [1:0]              prefix_progress_next;
  logic                    digit_index_next;
  logic                    escape_seen_next;
  logic [7:0]              byte_acc_next;
  logic [2:0]              bytes_taken_next;
  logic [15:0]             running_crc_next;
  logic [GarbageWidth-1:0] garbage_count_next;
  logic [CancelWidth-1:0]  cancel_count_next;
  logic                    hex_mode_next;
  logic [7:0]              type_byte_next;
  logic [31:0]             data_word_next;

  logic        emit;
  logic [1:0]  status_next;
  logic [7:0]  frame_type_next;
  logic [31:0] header_value_next;
  logic        hex_framed_next;
  logic [2:0]  failure_kind_next;

  logic        in_accept;
  logic        advance;
  logic        out_taken;

  logic [6:0]  c7;
  logic [3:0]  digit;
  logic        take;
  logic [7:0]  take_value;

  assign cfg_ready = 1'b1;

  // The item moves on whenever the output register is free or being emptied.
  assign out_taken = out_valid && !out_stall;
  assign advance   = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign c7        = item_byte[6:0];

  always_comb begin
    phase_next           = phase;
    prefix_progress_next = prefix_progress;
    digit_index_next     = digit_index;
    escape_seen_next     = escape_seen;
    byte_acc_next        = byte_acc;
    bytes_taken_next     = bytes_taken;
    running_crc_next     = running_crc;
    garbage_count_next   = garbage_count;
    cancel_count_next    = cancel_count;
    hex_mode_next        = hex_mode;
    type_byte_next       = type_byte;
    data_word_next       = data_word;
    emit                 = 1'b0;
    status_next          = ST_OK;
    digit                = 4'd0;
    take                 = 1'b0;
    take_value           = 8'd0;

    if (item_fail) begin
      emit        = 1'b1;
      status_next = ST_IOFAIL;
    end else if (c7 != CH_XON && c7 != CH_XOFF) begin
      if (c7 == CH_CAN) begin
        if (cancel_count != {CancelWidth{1'b1}}) begin
          cancel_count_next = cancel_count + CancelWidth'(1);
        end
        if (cancel_count_next >= cancel_run) begin
          emit        = 1'b1;
          status_next = ST_CANCEL;
        end
      end else begin
        cancel_count_next = '0;
      end

      if (!emit) begin
        case (phase)
          PH_HUNT: begin
            if (c7 == CH_PAD) begin
              prefix_progress_next = 2'd1;
            end else if (prefix_progress == 2'd1 && c7 == CH_CAN) begin
              prefix_progress_next = 2'd2;
            end else if (prefix_progress == 2'd2 && (c7 == CH_BIN16 || c7 == CH_HEX)) begin
              hex_mode_next        = (c7 == CH_HEX);
              phase_next           = (c7 == CH_HEX) ? PH_HEX : PH_BIN;
              prefix_progress_next = 2'd0;
              running_crc_next     = '0;
              bytes_taken_next     = '0;
              byte_acc_next        = '0;
              digit_index_next     = 1'b0;
              escape_seen_next     = 1'b0;
            end else begin
              prefix_progress_next = 2'd0;
            end
            // Anything that leaves the prefix matcher at rest counts as garbage.
            if (phase_next == PH_HUNT && prefix_progress_next == 2'd0) begin
              if (garbage_count != {GarbageWidth{1'b1}}) begin
                garbage_count_next = garbage_count + GarbageWidth'(1);
              end
              if (garbage_count_next >= garbage_limit) begin
                emit        = 1'b1;
                status_next = ST_CANCEL;
              end
            end
          end
          PH_HEX: begin
            if (c7 inside {[7'h30:7'h39]}) begin
              digit = c7[3:0];
            end else if (c7 inside {[7'h61:7'h66]}) begin
              digit = c7[3:0] + 4'd9;
            end else begin
              emit        = 1'b1;
              status_next = ST_BAD;
            end
            if (!emit) begin
              byte_acc_next = {byte_acc[3:0], digit};
              if (!digit_index) begin
                digit_index_next = 1'b1;
              end else begin
                take       = 1'b1;
                take_value = {byte_acc[3:0], digit};
              end
            end
          end
          PH_BIN: begin
            if (item_byte == ESC_BYTE) begin
              escape_seen_next = 1'b1;
            end else if (!escape_seen) begin
              take       = 1'b1;
              take_value = item_byte;
            end else if (item_byte == ESC_RUB0) begin
              take       = 1'b1;
              take_value = 8'h7F;
            end else if (item_byte == ESC_RUB1) begin
              take       = 1'b1;
              take_value = 8'hFF;
            end else if (item_byte[6:5] == 2'b10) begin
              take       = 1'b1;
              take_value = item_byte ^ 8'h40;
            end else begin
              emit        = 1'b1;
              status_next = ST_BAD;
            end
          end
          default: begin
            if (c7 == CH_LF) begin
              emit        = 1'b1;
              status_next = ST_OK;
            end
          end
        endcase
      end

      if (take) begin
        running_crc_next = zhr_crc_step(running_crc, take_value);
        case (bytes_taken)
          3'd0:    type_byte_next = take_value;
          3'd1:    data_word_next[7:0]   = data_word[7:0]   | take_value;
          3'd2:    data_word_next[15:8]  = data_word[15:8]  | take_value;
          3'd3:    data_word_next[23:16] = data_word[23:16] | take_value;
          3'd4:    data_word_next[31:24] = data_word[31:24] | take_value;
          default: data_word_next = data_word;
        endcase
        bytes_taken_next = bytes_taken + 3'd1;
        if (bytes_taken != 3'd6) begin
          byte_acc_next    = '0;
          digit_index_next = 1'b0;
          escape_seen_next = 1'b0;
        end else if (running_crc_next != 16'd0) begin
          emit        = 1'b1;
          status_next = ST_BAD;
        end else if (hex_mode) begin
          phase_next = PH_TRAIL;
        end else begin
          emit        = 1'b1;
          status_next = ST_OK;
        end
      end
    end

    frame_type_next   = (status_next == ST_OK) ? type_byte_next : 8'd0;
    header_value_next = data_word_next;
    hex_framed_next   = hex_mode_next;
    failure_kind_next = (status_next == ST_IOFAIL) ? item_code : 3'd0;

    // A result always returns the decoder to the hunt.
    if (emit) begin
      phase_next           = PH_HUNT;
      prefix_progress_next = '0;
      digit_index_next     = 1'b0;
      escape_seen_next     = 1'b0;
      byte_acc_next        = '0;
      bytes_taken_next     = '0;
      running_crc_next     = '0;
      garbage_count_next   = '0;
      cancel_count_next    = '0;
      hex_mode_next        = 1'b0;
      type_byte_next       = '0;
      data_word_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      garbage_limit   <= GARBAGE_LIMIT_RESET;
      cancel_run      <= CANCEL_RUN_RESET;
      item_valid      <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_HUNT;
      prefix_progress <= '0;
      digit_index     <= 1'b0;
      escape_seen     <= 1'b0;
      byte_acc        <= '0;
      bytes_taken     <= '0;
      running_crc     <= '0;
      garbage_count   <= '0;
      cancel_count    <= '0;
      hex_mode        <= 1'b0;
      type_byte       <= '0;
      data_word       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GARBAGE_LIMIT: garbage_limit <= cfg_data;
          CFG_CANCEL_RUN:    cancel_run    <= cfg_data[CancelWidth-1:0];
          default:           garbage_limit <= garbage_limit;
        endcase
      end

      if (in_accept) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end

      if (advance) begin
        phase           <= phase_next;
        prefix_progress <= prefix_progress_next;
        digit_index     <= digit_index_next;
        escape_seen     <= escape_seen_next;
        byte_acc        <= byte_acc_next;
        bytes_taken     <= bytes_taken_next;
        running_crc     <= running_crc_next;
        garbage_count   <= garbage_count_next;
        cancel_count    <= cancel_count_next;
        hex_mode        <= hex_mode_next;
        type_byte       <= type_byte_next;
        data_word       <= data_word_next;
      end

      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_byte <= rx_byte;
      item_fail <= io_fail;
      item_code <= fail_code;
    end
    if (advance && emit) begin
      status       <= status_next;
      frame_type   <= frame_type_next;
      header_value <= header_value_next;
      hex_framed   <= hex_framed_next;
      failure_kind <= failure_kind_next;
    end
  end

  // A result leaves the decoder back in the hunt with nothing collected.
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> phase == PH_HUNT && bytes_taken == 3'd0 && data_word == 32'd0)
    else $error("decoder state not cleared after a result");

  // The input side only waits on a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled without a held result");

  // The trailer is only reached after all seven hex bytes.
  a_trailer_entry: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAIL |-> hex_mode && bytes_taken == 3'd7)
    else $error("trailer phase entered early");

  // The prefix matcher is idle outside the hunt.
  a_prefix_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HUNT |-> prefix_progress == 2'd0)
    else $error("prefix progress set outside the hunt");

  // Only a good header reports its type, only an I/O failure its kind.
  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || frame_type == 8'd0) &&
                  (status == ST_IOFAIL || failure_kind == 3'd0))
    else $error("result fields inconsistent with status");

endmodule
`default_nettype wire
